// ===== rtl/voice_allocator_stealing_defines.svh =====
// assertion macros for the voice allocator checker
// expects clk_i and rst_ni in the scope of each use
`ifndef VOICE_ALLOCATOR_STEALING_DEFINES_SVH
`define VOICE_ALLOCATOR_STEALING_DEFINES_SVH

// same-cycle implication
`define VAS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("voice allocator check failed");

// next-cycle implication
`define VAS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("voice allocator check failed");

`endif

// ===== rtl/vas_pkg.sv =====
// shared types, codes and the slot ranking function of the voice allocator
// no dependencies
`default_nettype none

package vas_pkg;

  localparam int NOTE_W = 7;
  localparam int CH_W = 4;
  localparam int ID_W = 32;
  localparam int VEL_W = 16;
  localparam int LVL_W = 16;
  localparam int ORD_W = 32;
  localparam int OUT_SLOT_W = 4;

  typedef enum logic [1:0] {
    FN_NOTE_ON  = 2'd0,
    FN_NOTE_OFF = 2'd1,
    FN_ALL_OFF  = 2'd2,
    FN_REPORT   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_START   = 3'd1,
    OP_RELEASE = 3'd2,
    OP_REL_ALL = 3'd3,
    OP_REPORT  = 3'd4
  } op_e;

  // lower rank is preferred
  localparam logic [1:0] RANK_FREE = 2'd0;
  localparam logic [1:0] RANK_REL  = 2'd1;
  localparam logic [1:0] RANK_HELD = 2'd2;

  typedef struct packed {
    logic             found;
    logic [1:0]       rank;
    logic [LVL_W-1:0] level;
    logic [ORD_W-1:0] order;
  } cand_t;

  typedef struct packed {
    logic              note_on;
    logic [NOTE_W-1:0] note;
    logic [CH_W-1:0]   channel;
    logic [ID_W-1:0]   note_id;
  } srch_t;

  typedef struct packed {
    op_e               op;
    logic [NOTE_W-1:0] note;
    logic [CH_W-1:0]   channel;
    logic [ID_W-1:0]   note_id;
    logic              report_active;
    logic [LVL_W-1:0]  level;
    logic [ORD_W-1:0]  order;
  } upd_t;

  // true when a (a later slot) beats b; ties keep b
  function automatic logic better(cand_t a, cand_t b);
    logic r;
    r = 1'b0;
    if (a.rank < b.rank) begin
      r = 1'b1;
    end else if (a.rank == b.rank) begin
      if (a.rank == RANK_REL) begin
        r = (a.level < b.level) || ((a.level == b.level) && (a.order < b.order));
      end else if (a.rank == RANK_HELD) begin
        r = a.order < b.order;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vas_cell.sv =====
// one voice slot: holds the slot state and passes the search candidate on
// depends on vas_pkg
`default_nettype none

module vas_cell #(
  parameter int SW  = 4,
  parameter int IDX = 0
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire vas_pkg::srch_t  srch_i,
  input  wire vas_pkg::upd_t   upd_i,
  input  wire                  sel_i,
  input  wire                  tok_vld_i,
  input  wire vas_pkg::cand_t  tok_i,
  input  wire [SW-1:0]         tok_slot_i,
  output logic                 tok_vld_o,
  output vas_pkg::cand_t       tok_o,
  output logic [SW-1:0]        tok_slot_o
);

  logic                          active_q, active_d;
  logic                          rel_q, rel_d;
  logic [vas_pkg::LVL_W-1:0]     level_q, level_d;
  logic [vas_pkg::ORD_W-1:0]     order_q, order_d;
  logic [vas_pkg::NOTE_W-1:0]    note_q, note_d;
  logic [vas_pkg::CH_W-1:0]      ch_q, ch_d;
  logic [vas_pkg::ID_W-1:0]      id_q, id_d;

  logic                          tvld_q;
  vas_pkg::cand_t                tok_q, tok_d;
  logic [SW-1:0]                 tslot_q, tslot_d;

  vas_pkg::cand_t                own;
  logic                          match;

  always_comb begin
    match = active_q && !rel_q && (note_q == srch_i.note) && (ch_q == srch_i.channel)
            && ((srch_i.note_id == '0) || (id_q == srch_i.note_id));
    own.level = level_q;
    own.order = order_q;
    if (srch_i.note_on) begin
      own.found = 1'b1;
      if (!active_q) begin
        own.rank = vas_pkg::RANK_FREE;
      end else if (rel_q) begin
        own.rank = vas_pkg::RANK_REL;
      end else begin
        own.rank = vas_pkg::RANK_HELD;
      end
    end else begin
      own.found = match;
      own.rank  = vas_pkg::RANK_HELD;
    end
  end

  always_comb begin
    if (own.found && (!tok_i.found || vas_pkg::better(own, tok_i))) begin
      tok_d   = own;
      tslot_d = SW'(IDX);
    end else begin
      tok_d   = tok_i;
      tslot_d = tok_slot_i;
    end
  end

  always_comb begin
    active_d = active_q;
    rel_d    = rel_q;
    level_d  = level_q;
    order_d  = order_q;
    note_d   = note_q;
    ch_d     = ch_q;
    id_d     = id_q;
    unique case (upd_i.op)
      vas_pkg::OP_NONE: begin
      end
      vas_pkg::OP_START: begin
        if (sel_i) begin
          active_d = 1'b1;
          rel_d    = 1'b0;
          level_d  = '0;
          order_d  = upd_i.order;
          note_d   = upd_i.note;
          ch_d     = upd_i.channel;
          id_d     = upd_i.note_id;
        end
      end
      vas_pkg::OP_RELEASE: begin
        if (sel_i) begin
          rel_d = 1'b1;
        end
      end
      vas_pkg::OP_REL_ALL: begin
        if (active_q) begin
          rel_d = 1'b1;
        end
      end
      vas_pkg::OP_REPORT: begin
        if (sel_i) begin
          level_d = upd_i.level;
          if (!upd_i.report_active) begin
            active_d = 1'b0;
            rel_d    = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      rel_q    <= 1'b0;
      level_q  <= '0;
      order_q  <= '0;
      note_q   <= '0;
      ch_q     <= '0;
      id_q     <= '0;
      tvld_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      rel_q    <= rel_d;
      level_q  <= level_d;
      order_q  <= order_d;
      note_q   <= note_d;
      ch_q     <= ch_d;
      id_q     <= id_d;
      tvld_q   <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q   <= tok_d;
    tslot_q <= tslot_d;
  end

  assign tok_vld_o  = tvld_q;
  assign tok_o      = tok_q;
  assign tok_slot_o = tslot_q;

endmodule

`default_nettype wire

// ===== rtl/voice_allocator_stealing.sv =====
// top level of the voice allocator: event sequencer and the row of slot cells
// depends on vas_pkg and vas_cell
//
// An item is taken when start is high and busy is low. For note on and note
// off, a search candidate walks the row of VOICES slot cells, one cell per
// cycle, and the winning slot is updated in the cycle after it leaves the
// last cell, when the result strobe is registered. All notes off, voice
// reports and note events refused while engine_ready is low skip the search.
// busy stays high until the result is shown; the next item can be taken in the
// cycle the result strobe is high. done_o is high for exactly one cycle per
// item and the receiver cannot stall it. Slot state is cleared by reset
// directly; engine_ready is written through cfg_we_i / cfg_wdata_i, which the
// user must do only while idle; the block does not enforce this.
`default_nettype none

module voice_allocator_stealing #(
  parameter int VOICES = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire                                cfg_wdata_i,
  input  wire                                start,
  output logic                               busy,
  input  wire [1:0]                          func_i,
  input  wire [vas_pkg::NOTE_W-1:0]          note_i,
  input  wire [vas_pkg::CH_W-1:0]            channel_i,
  input  wire [vas_pkg::ID_W-1:0]            note_id_i,
  input  wire [vas_pkg::VEL_W-1:0]           velocity_i,
  input  wire [3:0]                          report_slot_i,
  input  wire                                report_active_i,
  input  wire [vas_pkg::LVL_W-1:0]           report_level_i,
  output logic                               done_o,
  output logic                               accepted_o,
  output logic                               voice_started_o,
  output logic [vas_pkg::OUT_SLOT_W-1:0]     start_slot_o,
  output logic                               stolen_o,
  output logic [vas_pkg::VEL_W-1:0]          start_velocity_o,
  output logic [vas_pkg::ORD_W-1:0]          start_order_o,
  output logic                               release_valid_o,
  output logic [vas_pkg::OUT_SLOT_W-1:0]     release_slot_o,
  output logic                               release_all_o
);

  localparam int SW = $clog2(VOICES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DISP = 3'b010,
    S_SCAN = 3'b100
  } state_e;

  state_e                        state_q, state_d;
  logic                          ready_q;
  logic [vas_pkg::ORD_W-1:0]     order_q, order_d;

  vas_pkg::func_e                func_q;
  logic [vas_pkg::NOTE_W-1:0]    note_q;
  logic [vas_pkg::CH_W-1:0]      ch_q;
  logic [vas_pkg::ID_W-1:0]      id_q;
  logic [vas_pkg::VEL_W-1:0]     vel_q;
  logic [3:0]                    rslot_q;
  logic                          ract_q;
  logic [vas_pkg::LVL_W-1:0]     rlev_q;

  logic                          done_q, done_d;
  logic                          acc_q, acc_d;
  logic                          vs_q, vs_d;
  logic [vas_pkg::OUT_SLOT_W-1:0] sslot_q, sslot_d;
  logic                          stolen_q, stolen_d;
  logic [vas_pkg::VEL_W-1:0]     svel_q, svel_d;
  logic [vas_pkg::ORD_W-1:0]     sord_q, sord_d;
  logic                          rv_q, rv_d;
  logic [vas_pkg::OUT_SLOT_W-1:0] rslot_out_q, rslot_out_d;
  logic                          rall_q, rall_d;

  logic                          take;
  logic                          launch;
  logic                          use_report;
  logic                          note_on;
  logic                          rep_ok;
  vas_pkg::srch_t                srch;
  vas_pkg::upd_t                 upd;
  logic [VOICES-1:0]             sel;
  logic [SW-1:0]                 pick;
  logic [SW+3:0]                 pick_ext;
  vas_pkg::cand_t                fin;

  vas_pkg::cand_t                tok   [VOICES+1];
  logic [SW-1:0]                 tslot [VOICES+1];
  logic [VOICES:0]               tvld;

  assign take     = start && !busy;
  assign busy     = (state_q != S_IDLE);
  assign note_on  = (func_q == vas_pkg::FN_NOTE_ON) && (vel_q != '0);
  assign rep_ok   = 32'(rslot_q) < VOICES;
  assign pick     = tslot[VOICES];
  assign fin      = tok[VOICES];
  assign pick_ext = {4'b0000, pick};

  assign srch.note_on = note_on;
  assign srch.note    = note_q;
  assign srch.channel = ch_q;
  assign srch.note_id = id_q;

  assign tok[0]   = '0;
  assign tslot[0] = '0;
  assign tvld[0]  = launch;

  for (genvar g = 0; g < VOICES; g++) begin : g_cell
    vas_cell #(
      .SW  (SW),
      .IDX (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .srch_i     (srch),
      .upd_i      (upd),
      .sel_i      (sel[g]),
      .tok_vld_i  (tvld[g]),
      .tok_i      (tok[g]),
      .tok_slot_i (tslot[g]),
      .tok_vld_o  (tvld[g+1]),
      .tok_o      (tok[g+1]),
      .tok_slot_o (tslot[g+1])
    );
  end

  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      sel[i] = use_report ? (32'(rslot_q) == i) : (32'(pick) == i);
    end
  end

  always_comb begin
    state_d     = state_q;
    order_d     = order_q;
    launch      = 1'b0;
    use_report  = 1'b0;
    upd.op            = vas_pkg::OP_NONE;
    upd.note          = note_q;
    upd.channel       = ch_q;
    upd.note_id       = id_q;
    upd.report_active = ract_q;
    upd.level         = rlev_q;
    upd.order         = order_q + 1'b1;
    done_d      = 1'b0;
    acc_d       = 1'b0;
    vs_d        = 1'b0;
    sslot_d     = '0;
    stolen_d    = 1'b0;
    svel_d      = '0;
    sord_d      = '0;
    rv_d        = 1'b0;
    rslot_out_d = '0;
    rall_d      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (func_q == vas_pkg::FN_REPORT) begin
          use_report = 1'b1;
          if (rep_ok) begin
            upd.op = vas_pkg::OP_REPORT;
          end
          acc_d   = rep_ok;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (!ready_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (func_q == vas_pkg::FN_ALL_OFF) begin
          upd.op  = vas_pkg::OP_REL_ALL;
          acc_d   = 1'b1;
          rall_d  = 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          launch  = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tvld[VOICES]) begin
          done_d  = 1'b1;
          acc_d   = 1'b1;
          state_d = S_IDLE;
          if (note_on) begin
            upd.op   = vas_pkg::OP_START;
            order_d  = order_q + 1'b1;
            vs_d     = 1'b1;
            sslot_d  = pick_ext[3:0];
            stolen_d = (fin.rank != vas_pkg::RANK_FREE);
            svel_d   = vel_q;
            sord_d   = order_q + 1'b1;
          end else if (fin.found) begin
            upd.op      = vas_pkg::OP_RELEASE;
            rv_d        = 1'b1;
            rslot_out_d = pick_ext[3:0];
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b0;
      order_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      order_q <= order_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        ready_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      func_q  <= vas_pkg::func_e'(func_i);
      note_q  <= note_i;
      ch_q    <= channel_i;
      id_q    <= note_id_i;
      vel_q   <= velocity_i;
      rslot_q <= report_slot_i;
      ract_q  <= report_active_i;
      rlev_q  <= report_level_i;
    end
    acc_q       <= acc_d;
    vs_q        <= vs_d;
    sslot_q     <= sslot_d;
    stolen_q    <= stolen_d;
    svel_q      <= svel_d;
    sord_q      <= sord_d;
    rv_q        <= rv_d;
    rslot_out_q <= rslot_out_d;
    rall_q      <= rall_d;
  end

  assign done_o           = done_q;
  assign accepted_o       = acc_q;
  assign voice_started_o  = vs_q;
  assign start_slot_o     = sslot_q;
  assign stolen_o         = stolen_q;
  assign start_velocity_o = svel_q;
  assign start_order_o    = sord_q;
  assign release_valid_o  = rv_q;
  assign release_slot_o   = rslot_out_q;
  assign release_all_o    = rall_q;

endmodule

`default_nettype wire

// ===== rtl/vas_checker.sv =====
// port-level checks of the voice allocator, bound to the top level
// depends on voice_allocator_stealing_defines.svh
`default_nettype none

`include "voice_allocator_stealing_defines.svh"

module vas_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire start,
  input wire busy,
  input wire done_o,
  input wire accepted_o,
  input wire voice_started_o,
  input wire release_valid_o,
  input wire release_all_o
);

  // an accepted item keeps the block busy until its result
  `VAS_ASSERT_NXT(a_take_busy, start && !busy, busy)
  // leaving busy always comes with a result
  `VAS_ASSERT_IMP(a_fell_done, $fell(busy), done_o)
  // results never come in consecutive cycles
  `VAS_ASSERT_NXT(a_done_gap, done_o, !done_o)
  // any action in a result means the event was accepted
  `VAS_ASSERT_IMP(a_act_acc, voice_started_o || release_valid_o || release_all_o,
                  done_o && accepted_o)

endmodule

bind voice_allocator_stealing vas_checker u_vas_checker (.*);

`default_nettype wire
